[rtl/ipv4dq_pkg.sv]
`timescale 1ns / 1ps

package ipv4dq_pkg;

  localparam int unsigned PhaseW = 3;

  // Parser phases.
  localparam logic [PhaseW-1:0] PhPre    = 3'd0; // whitespace before a field
  localparam logic [PhaseW-1:0] PhSign   = 3'd1; // sign seen, a digit must follow
  localparam logic [PhaseW-1:0] PhDigits = 3'd2; // inside the digits of a field
  localparam logic [PhaseW-1:0] PhDot    = 3'd3; // field done, waiting for a dot
  localparam logic [PhaseW-1:0] PhTrail  = 3'd4; // last field done, only blanks
  localparam logic [PhaseW-1:0] PhError  = 3'd5; // string already invalid

  localparam logic [7:0] ChNul   = 8'd0;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChPlus  = 8'd43;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] ChDot   = 8'd46;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChCr    = 8'd13;

  localparam logic [8:0] FieldSat = 9'd256;
  localparam logic [1:0] LastField = 2'd3;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

[rtl/ipv4_dotted_quad_parser.sv]
`timescale 1ns / 1ps

// Dotted-quad IPv4 address parser.
// The input channel carries one character per word (char_code_i); a zero
// character ends the string. Every other character produces no result. At
// the terminator one result word leaves on the output channel: is_valid_o and
// packed_address_o, with the fourth field in the top byte and zero when the
// string is not a legal address.
// One character is taken every cycle while in_stall_o is low. A character is
// registered on acceptance and parsed in the next cycle by a single pass of
// logic that updates the parse state; the result of a terminator is written
// to the output register when the terminator is parsed.
// The output register holds a result while the receiver stalls. Ordinary
// characters keep flowing during that time; only a second terminator waits
// in the input register, and then in_stall_o goes high until the pending
// result is taken.
// Reset clears the parse state and both valid flags; the parser then expects
// the first field of a new string.
module ipv4_dotted_quad_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_valid_o,
  output logic [31:0] packed_address_o
);

  logic        in_vld_q;
  logic [7:0]  char_q;
  logic [ipv4dq_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [8:0]  fval_q, fval_d;
  logic        neg_q, neg_d;
  logic [31:0] addr_q, addr_d;
  logic        out_vld_q, out_vld_d;
  logic        ok_q, ok_d;
  logic [31:0] res_q, res_d;

  logic        is_term;
  logic        can_go;
  logic        proc;
  logic        out_free;
  logic        last;
  logic        fin_ok;
  logic [31:0] addr_ins;
  logic [11:0] acc;
  logic [8:0]  acc_sat;
  logic        c_space;
  logic        c_digit;

  assign is_term  = (char_q == ipv4dq_pkg::ChNul);
  assign out_free = !out_vld_q || !out_stall_i;
  assign can_go   = !is_term || out_free;
  assign proc     = in_vld_q && can_go;
  assign in_stall_o = in_vld_q && !can_go;

  assign c_space = ipv4dq_pkg::is_space(char_q);
  assign c_digit = ipv4dq_pkg::is_digit(char_q);
  assign last    = (idx_q == ipv4dq_pkg::LastField);

  // A field is good when it fits a byte and is not a nonzero negative value.
  assign fin_ok   = !fval_q[8] && !(neg_q && (fval_q != 9'd0));
  assign addr_ins = addr_q | ({24'd0, fval_q[7:0]} << {idx_q, 3'b000});

  assign acc     = ({3'd0, fval_q} * 12'd10) + {8'd0, char_q[3:0]};
  assign acc_sat = (acc > {3'd0, ipv4dq_pkg::FieldSat}) ? ipv4dq_pkg::FieldSat : acc[8:0];

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    fval_d    = fval_q;
    neg_d     = neg_q;
    addr_d    = addr_q;
    out_vld_d = out_vld_q && out_stall_i;
    ok_d      = ok_q;
    res_d     = res_q;
    if (proc) begin
      if (is_term) begin
        out_vld_d = 1'b1;
        ok_d      = 1'b0;
        res_d     = 32'd0;
        if (phase_q == ipv4dq_pkg::PhTrail) begin
          ok_d  = 1'b1;
          res_d = addr_q;
        end else if ((phase_q == ipv4dq_pkg::PhDigits) && last && fin_ok) begin
          ok_d  = 1'b1;
          res_d = addr_ins;
        end
        phase_d = ipv4dq_pkg::PhPre;
        idx_d   = 2'd0;
        fval_d  = 9'd0;
        neg_d   = 1'b0;
        addr_d  = 32'd0;
      end else begin
        unique case (phase_q)
          ipv4dq_pkg::PhPre: begin
            if (c_space) begin
              phase_d = ipv4dq_pkg::PhPre;
            end else if ((char_q == ipv4dq_pkg::ChPlus) || (char_q == ipv4dq_pkg::ChMinus)) begin
              neg_d   = (char_q == ipv4dq_pkg::ChMinus);
              phase_d = ipv4dq_pkg::PhSign;
            end else if (c_digit) begin
              fval_d  = {5'd0, char_q[3:0]};
              phase_d = ipv4dq_pkg::PhDigits;
            end else begin
              phase_d = ipv4dq_pkg::PhError;
            end
          end
          ipv4dq_pkg::PhSign: begin
            if (c_digit) begin
              fval_d  = {5'd0, char_q[3:0]};
              phase_d = ipv4dq_pkg::PhDigits;
            end else begin
              phase_d = ipv4dq_pkg::PhError;
            end
          end
          ipv4dq_pkg::PhDigits: begin
            if (c_digit) begin
              fval_d = acc_sat;
            end else if (c_space) begin
              if (fin_ok) begin
                addr_d  = addr_ins;
                phase_d = last ? ipv4dq_pkg::PhTrail : ipv4dq_pkg::PhDot;
              end else begin
                phase_d = ipv4dq_pkg::PhError;
              end
            end else if ((char_q == ipv4dq_pkg::ChDot) && !last) begin
              if (fin_ok) begin
                addr_d  = addr_ins;
                idx_d   = idx_q + 2'd1;
                fval_d  = 9'd0;
                neg_d   = 1'b0;
                phase_d = ipv4dq_pkg::PhPre;
              end else begin
                phase_d = ipv4dq_pkg::PhError;
              end
            end else begin
              phase_d = ipv4dq_pkg::PhError;
            end
          end
          ipv4dq_pkg::PhDot: begin
            if (c_space) begin
              phase_d = ipv4dq_pkg::PhDot;
            end else if ((char_q == ipv4dq_pkg::ChDot) && !last) begin
              idx_d   = idx_q + 2'd1;
              fval_d  = 9'd0;
              neg_d   = 1'b0;
              phase_d = ipv4dq_pkg::PhPre;
            end else begin
              phase_d = ipv4dq_pkg::PhError;
            end
          end
          ipv4dq_pkg::PhTrail: begin
            if (!c_space) begin
              phase_d = ipv4dq_pkg::PhError;
            end
          end
          default: begin
            phase_d = ipv4dq_pkg::PhError;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= ipv4dq_pkg::PhPre;
      idx_q     <= 2'd0;
      fval_q    <= 9'd0;
      neg_q     <= 1'b0;
      addr_q    <= 32'd0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      out_vld_q <= out_vld_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      fval_q    <= fval_d;
      neg_q     <= neg_d;
      addr_q    <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= char_code_i;
    end
    ok_q  <= ok_d;
    res_q <= res_d;
  end

  assign out_valid_o      = out_vld_q;
  assign is_valid_o       = ok_q;
  assign packed_address_o = res_q;

endmodule

[rtl/ipv4dq_checker.sv]
`timescale 1ns / 1ps

module ipv4dq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  char_code_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        is_valid_o,
  input logic [31:0] packed_address_o
);

  // A pending result is never dropped while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(is_valid_o) && $stable(packed_address_o))
    else $error("result word changed under stall");

  // The input side only backs up when a result is waiting on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // An invalid string reports a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_valid_o |-> packed_address_o == 32'd0)
    else $error("invalid result with nonzero address");

  // A fresh result follows an accepted terminator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && (char_code_i == ipv4dq_pkg::ChNul), 2))
    else $error("result without a matching terminator");

endmodule

bind ipv4_dotted_quad_parser ipv4dq_checker u_ipv4dq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .char_code_i      (char_code_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .is_valid_o       (is_valid_o),
  .packed_address_o (packed_address_o)
);
